// ===== rtl/clc_pkg.sv =====
// Shared constants, codes and port structs for the circular list cursor engine.
`default_nettype none

package clc_pkg;

  // Pool size and field widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FUNC_W   = 3;
  localparam int VAL_W    = 32;
  localparam int ENT_W    = 7;
  localparam int ERR_W    = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_INS_BEFORE = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_AFTER  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_STEP_NEXT  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_STEP_PREV  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ       = 3'd5;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // Port of an index-wide memory
  typedef struct packed {
    logic we;
    idx_t waddr;
    idx_t wdata;
    idx_t raddr;
  } link_port_t;

  // Port of the value memory
  typedef struct packed {
    logic             we;
    idx_t             waddr;
    logic [VAL_W-1:0] wdata;
    idx_t             raddr;
  } val_port_t;

endpackage

`default_nettype wire

// ===== rtl/circular_list_cursor_engine.sv =====
// Top level: circular list with cursor over a node pool held in block memories.
//
// Usage:
//   Input channel (in_valid / in_stall, in_func, in_value) carries one operation
//   word: insert before / after the cursor, remove the cursor node, step next,
//   step previous or read. Every word yields exactly one result word on the
//   output channel (out_valid / out_stall): value at the cursor, entry count,
//   empty flag and error code (empty ring, or full pool on insert).
//   A word is taken when valid is high and stall is low at a rising edge.
//   The word passes the states S_LINK, S_FIX and S_DONE before its result is
//   registered; no new word is taken until then. The accept cycle issues the
//   cursor-link read, then come the first link writes, the neighbor link writes
//   with the value read, and the result load, on one-write one-read memories.
//   Reset (rst_n low, synchronous) empties the ring, puts the cursor at node
//   zero and refills the free stack at once; no clearing pass is needed.
//   When the receiver stalls, the result holds in the output register; the
//   next word is still taken and worked, and waits only for the register.
`default_nettype none

module circular_list_cursor_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [clc_pkg::FUNC_W-1:0] in_func,
  input  logic [clc_pkg::VAL_W-1:0]  in_value,
  output logic                       in_stall,
  output logic                       out_valid,
  output logic [clc_pkg::VAL_W-1:0]  out_current_value,
  output logic [clc_pkg::ENT_W-1:0]  out_entries,
  output logic                       out_is_empty,
  output logic [clc_pkg::ERR_W-1:0]  out_error,
  input  logic                       out_stall
);

  import clc_pkg::*;

  link_port_t       next_port, prev_port, free_port;
  val_port_t        val_port;
  idx_t             next_rdata, prev_rdata, free_rdata;
  logic [VAL_W-1:0] val_rdata;

  // Sequencer
  clc_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_func           (in_func),
    .in_value          (in_value),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_current_value (out_current_value),
    .out_entries       (out_entries),
    .out_is_empty      (out_is_empty),
    .out_error         (out_error),
    .out_stall         (out_stall),
    .next_port         (next_port),
    .prev_port         (prev_port),
    .free_port         (free_port),
    .val_port          (val_port),
    .next_rdata        (next_rdata),
    .prev_rdata        (prev_rdata),
    .free_rdata        (free_rdata),
    .val_rdata         (val_rdata)
  );

  // Forward links
  clc_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (next_port.we),
    .waddr (next_port.waddr),
    .wdata (next_port.wdata),
    .raddr (next_port.raddr),
    .rdata (next_rdata)
  );

  // Backward links
  clc_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (prev_port.we),
    .waddr (prev_port.waddr),
    .wdata (prev_port.wdata),
    .raddr (prev_port.raddr),
    .rdata (prev_rdata)
  );

  // Free-index stack
  clc_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (free_port.we),
    .waddr (free_port.waddr),
    .wdata (free_port.wdata),
    .raddr (free_port.raddr),
    .rdata (free_rdata)
  );

  // Node values
  clc_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_port.we),
    .waddr (val_port.waddr),
    .wdata (val_port.wdata),
    .raddr (val_port.raddr),
    .rdata (val_rdata)
  );

`ifndef SYNTH
  // An empty ring reports no entries and a zero value
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_current_value == '0) && (out_entries == '0))
    else $error("empty result carries data");

  // A non-empty ring reports at least one entry
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_empty |-> (out_entries != '0))
    else $error("non-empty result with zero entries");

  // One operation at a time: a taken word closes the input side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  // Only defined error codes leave the block
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error == ERR_OK) || (out_error == ERR_EMPTY) ||
                  (out_error == ERR_FULL))
    else $error("undefined error code");
`endif

endmodule

`default_nettype wire

// ===== rtl/clc_ram.sv =====
// Generic single-write, single-read memory with registered read data.
`default_nettype none

module clc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/clc_ctrl.sv =====
// Operation sequencer: cursor, counts, free-stack top and link rewrite steps.
`default_nettype none

module clc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  // Operation words
  input  logic                         in_valid,
  input  logic [clc_pkg::FUNC_W-1:0]   in_func,
  input  logic [clc_pkg::VAL_W-1:0]    in_value,
  output logic                         in_stall,
  // Result words
  output logic                         out_valid,
  output logic [clc_pkg::VAL_W-1:0]    out_current_value,
  output logic [clc_pkg::ENT_W-1:0]    out_entries,
  output logic                         out_is_empty,
  output logic [clc_pkg::ERR_W-1:0]    out_error,
  input  logic                         out_stall,
  // Memory ports
  output clc_pkg::link_port_t          next_port,
  output clc_pkg::link_port_t          prev_port,
  output clc_pkg::link_port_t          free_port,
  output clc_pkg::val_port_t           val_port,
  input  clc_pkg::idx_t                next_rdata,
  input  clc_pkg::idx_t                prev_rdata,
  input  clc_pkg::idx_t                free_rdata,
  input  logic [clc_pkg::VAL_W-1:0]    val_rdata
);

  import clc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LINK, S_FIX, S_DONE} state_t;

  state_t            state_r;
  logic [FUNC_W-1:0] func_r;
  logic [VAL_W-1:0]  value_r;
  idx_t              cursor_r;
  cnt_t              live_r;
  cnt_t              fc_r;
  cnt_t              minfc_r;
  idx_t              node_r;
  idx_t              old_r;
  idx_t              nb_r;
  logic              after_r;
  logic              fix_r;
  logic [ERR_W-1:0]  err_r;
  logic [ERR_W-1:0]  err_nxt;

  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;
  logic [ENT_W-1:0]  out_entries_r;
  logic              out_empty_r;
  logic [ERR_W-1:0]  out_error_r;

  logic is_ins, ins_after, live_zero, live_one, pool_full, push_ok;
  logic do_ins, do_rem, fresh;
  cnt_t pop_cnt;
  idx_t pop_idx, top_idx;

  // Decode and free-stack top; entries below the low-water mark still hold reset order
  always_comb begin
    is_ins    = (func_r == FN_INS_BEFORE) || (func_r == FN_INS_AFTER);
    ins_after = (func_r == FN_INS_AFTER);
    live_zero = (live_r == '0);
    live_one  = (live_r == cnt_t'(1));
    pool_full = (fc_r == '0);
    push_ok   = (fc_r < cnt_t'(CAPACITY));
    do_ins    = is_ins && !pool_full;
    do_rem    = (func_r == FN_REMOVE) && !live_zero;
    pop_cnt   = fc_r - cnt_t'(1);
    pop_idx   = pop_cnt[IDX_W-1:0];
    fresh     = (pop_cnt < minfc_r);
    top_idx   = fresh ? (IDX_W'(CAPACITY - 1) - pop_idx) : free_rdata;
    // full pool on insert, empty ring on any access
    err_nxt   = ERR_OK;
    if (is_ins && pool_full) begin
      err_nxt = ERR_FULL;
    end else if (live_zero && ((func_r == FN_REMOVE) || (func_r == FN_STEP_NEXT) ||
                               (func_r == FN_STEP_PREV) || (func_r == FN_READ))) begin
      err_nxt = ERR_EMPTY;
    end
  end

  // Memory commands; reads always follow the cursor and stack top
  always_comb begin
    next_port       = '0;
    prev_port       = '0;
    free_port       = '0;
    val_port        = '0;
    next_port.raddr = cursor_r;
    prev_port.raddr = cursor_r;
    free_port.raddr = pop_idx;
    val_port.raddr  = cursor_r;
    unique case (state_r)
      S_LINK: begin
        if (do_ins) begin
          val_port.we     = 1'b1;
          val_port.waddr  = top_idx;
          val_port.wdata  = value_r;
          next_port.we    = 1'b1;
          next_port.waddr = top_idx;
          prev_port.we    = 1'b1;
          prev_port.waddr = top_idx;
          if (live_zero) begin
            next_port.wdata = top_idx;
            prev_port.wdata = top_idx;
          end else if (ins_after) begin
            next_port.wdata = next_rdata;
            prev_port.wdata = cursor_r;
          end else begin
            next_port.wdata = cursor_r;
            prev_port.wdata = prev_rdata;
          end
        end else if (do_rem) begin
          if (!live_one) begin
            next_port.we    = 1'b1;
            next_port.waddr = prev_rdata;
            next_port.wdata = next_rdata;
            prev_port.we    = 1'b1;
            prev_port.waddr = next_rdata;
            prev_port.wdata = prev_rdata;
          end
          if (push_ok) begin
            free_port.we    = 1'b1;
            free_port.waddr = fc_r[IDX_W-1:0];
            free_port.wdata = cursor_r;
          end
        end
      end
      S_FIX: begin
        // neighbor links of an insert into a non-empty ring
        if (fix_r) begin
          next_port.we = 1'b1;
          prev_port.we = 1'b1;
          next_port.wdata = node_r;
          prev_port.wdata = node_r;
          if (after_r) begin
            prev_port.waddr = nb_r;
            next_port.waddr = old_r;
          end else begin
            next_port.waddr = nb_r;
            prev_port.waddr = old_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, ring state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      live_r      <= '0;
      fc_r        <= cnt_t'(CAPACITY);
      minfc_r     <= cnt_t'(CAPACITY);
      fix_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r  <= in_func;
            value_r <= in_value;
            state_r <= S_LINK;
          end
        end
        S_LINK: begin
          err_r   <= err_nxt;
          fix_r   <= do_ins && !live_zero;
          node_r  <= top_idx;
          old_r   <= cursor_r;
          after_r <= ins_after;
          nb_r    <= ins_after ? next_rdata : prev_rdata;
          if (is_ins) begin
            if (!pool_full) begin
              fc_r   <= pop_cnt;
              live_r <= live_r + cnt_t'(1);
              if (fresh) begin
                minfc_r <= pop_cnt;
              end
              if (live_zero) begin
                cursor_r <= top_idx;
              end
            end
          end else if (!live_zero) begin
            if (func_r == FN_REMOVE) begin
              live_r   <= live_r - cnt_t'(1);
              cursor_r <= live_one ? '0 : next_rdata;
              if (push_ok) begin
                fc_r <= fc_r + cnt_t'(1);
              end
            end else if (func_r == FN_STEP_NEXT) begin
              cursor_r <= next_rdata;
            end else if (func_r == FN_STEP_PREV) begin
              cursor_r <= prev_rdata;
            end
          end
          state_r <= S_FIX;
        end
        S_FIX: begin
          // value read at the final cursor is issued here
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_value_r   <= live_zero ? '0 : val_rdata;
            out_entries_r <= ENT_W'(live_r);
            out_empty_r   <= live_zero;
            out_error_r   <= err_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_current_value = out_value_r;
  assign out_entries       = out_entries_r;
  assign out_is_empty      = out_empty_r;
  assign out_error         = out_error_r;

endmodule

`default_nettype wire
